// ===== hw/rtl/pfa_pkg.sv =====
// Shared constants and types for the prime field ALU.
package pfa_pkg;

  localparam int unsigned WidthDefault = 63;

  typedef enum logic [2:0] {
    MODE_ADD = 3'd0,
    MODE_SUB = 3'd1,
    MODE_MUL = 3'd2,
    MODE_DIV = 3'd3,
    MODE_INV = 3'd4,
    MODE_NEG = 3'd5
  } pfa_mode_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RED_A,
    S_RED_B,
    S_DISPATCH,
    S_NEG,
    S_ADD,
    S_MUL,
    S_EUC_DIV,
    S_EUC_QRED,
    S_EUC_NEG,
    S_EUC_ADD,
    S_DONE
  } pfa_state_e;

endpackage

// ===== hw/rtl/pfa_req_if.sv =====
// Request and response channel interfaces of the prime field ALU.
interface pfa_req_if #(parameter int unsigned WIDTH = pfa_pkg::WidthDefault);
  logic             valid;
  logic             ready;
  logic [2:0]       mode;
  logic [WIDTH-1:0] operand_a;
  logic [WIDTH-1:0] operand_b;
  modport source (output valid, mode, operand_a, operand_b, input ready);
  modport sink   (input valid, mode, operand_a, operand_b, output ready);
endinterface

interface pfa_rsp_if #(parameter int unsigned WIDTH = pfa_pkg::WidthDefault);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] result;
  logic             status;
  modport source (output valid, result, status, input ready);
  modport sink   (input valid, result, status, output ready);
endinterface

// ===== hw/rtl/pfa_modadd.sv =====
// Shared add and conditional-subtract unit: s = a + b, minus m when that stays non-negative.
module pfa_modadd #(
  parameter int unsigned WIDTH = pfa_pkg::WidthDefault
) (
  input  logic [WIDTH+1:0] a_i,
  input  logic [WIDTH+1:0] b_i,
  input  logic [WIDTH+1:0] m_i,
  output logic [WIDTH+1:0] sum_o,
  output logic             ge_o
);
  logic [WIDTH+1:0] t;
  logic [WIDTH+1:0] u;

  assign t     = a_i + b_i;
  assign u     = t - m_i;
  assign ge_o  = ~u[WIDTH+1];
  assign sum_o = ge_o ? u : t;
endmodule

// ===== hw/rtl/prime_field_alu_unit.sv =====
// Top level of the prime field ALU: sequencer around one shared modular adder.
// One request at a time, all arithmetic on one add/compare-subtract unit. Operands are reduced
// by bit-serial restoring division, add and negate use the adder directly, and a multiply
// runs MSB-first double-and-add. An inverse runs extended Euclid: each iteration is a
// restoring division, a quotient fix-up, a multiply and then a negate and an add update;
// divide adds one more multiply. The result sits in an output register, so a new request
// is taken while the previous response still waits.
module prime_field_alu_unit #(
  parameter int unsigned WIDTH = pfa_pkg::WidthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [WIDTH-1:0] cfg_wdata_i,
  pfa_req_if.sink          req_i,
  pfa_rsp_if.source        rsp_o
);
  import pfa_pkg::*;

  localparam int unsigned CntW = $clog2(WIDTH + 1);

  pfa_state_e state_q, state_d;
  logic [WIDTH-1:0] mod_q;
  logic [WIDTH-1:0] p_q, p_d;
  logic [2:0]       mode_q, mode_d;
  logic [WIDTH-1:0] a_q, a_d, b_q, b_d;
  logic [WIDTH-1:0] r1_q, r1_d, t0_q, t0_d, t1_q, t1_d;
  logic [WIDTH-1:0] rem_q, rem_d, quo_q, quo_d, dq_q, dq_d;
  logic [WIDTH-1:0] mx_q, mx_d, my_q, my_d, acc_q, acc_d;
  logic [WIDTH-1:0] res_q, res_d;
  logic             st_q, st_d;
  logic             ctx_q, ctx_d;
  logic             phase_q, phase_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             ovalid_q, ovalid_d;
  logic [WIDTH-1:0] ores_q, ores_d;
  logic             ost_q, ost_d;

  logic [WIDTH+1:0] ua, ub, um, uout;
  logic             uge;
  logic [WIDTH-1:0] p_eff;
  logic             last;

  pfa_modadd #(.WIDTH(WIDTH)) u_modadd (
    .a_i(ua), .b_i(ub), .m_i(um), .sum_o(uout), .ge_o(uge)
  );

  assign p_eff = (mod_q < WIDTH'(2)) ? WIDTH'(2) : mod_q;
  assign last  = (cnt_q == CntW'(1));

  assign req_i.ready  = (state_q == S_IDLE);
  assign rsp_o.valid  = ovalid_q;
  assign rsp_o.result = ores_q;
  assign rsp_o.status = ost_q;

  always_comb begin
    state_d = state_q;
    p_d = p_q; mode_d = mode_q; a_d = a_q; b_d = b_q;
    r1_d = r1_q; t0_d = t0_q; t1_d = t1_q;
    rem_d = rem_q; quo_d = quo_q; dq_d = dq_q;
    mx_d = mx_q; my_d = my_q; acc_d = acc_q;
    res_d = res_q; st_d = st_q; ctx_d = ctx_q; phase_d = phase_q; cnt_d = cnt_q;
    ovalid_d = ovalid_q; ores_d = ores_q; ost_d = ost_q;
    ua = '0; ub = '0; um = {2'b00, p_q};

    if (ovalid_q && rsp_o.ready) ovalid_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          mode_d  = req_i.mode;
          a_d     = req_i.operand_a;
          b_d     = req_i.operand_b;
          p_d     = p_eff;
          rem_d   = '0;
          cnt_d   = CntW'(WIDTH);
          state_d = S_RED_A;
        end
      end
      S_RED_A: begin
        ua    = {1'b0, rem_q, a_q[WIDTH-1]};
        rem_d = uout[WIDTH-1:0];
        a_d   = {a_q[WIDTH-2:0], 1'b0};
        cnt_d = cnt_q - CntW'(1);
        if (last) begin
          a_d     = uout[WIDTH-1:0];
          rem_d   = '0;
          cnt_d   = CntW'(WIDTH);
          state_d = S_RED_B;
        end
      end
      S_RED_B: begin
        ua    = {1'b0, rem_q, b_q[WIDTH-1]};
        rem_d = uout[WIDTH-1:0];
        b_d   = {b_q[WIDTH-2:0], 1'b0};
        cnt_d = cnt_q - CntW'(1);
        if (last) begin
          b_d     = uout[WIDTH-1:0];
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        rem_d   = '0;
        quo_d   = '0;
        acc_d   = '0;
        phase_d = 1'b0;
        cnt_d   = CntW'(WIDTH);
        st_d    = 1'b0;
        res_d   = '0;
        case (mode_q)
          MODE_ADD: state_d = S_ADD;
          MODE_SUB, MODE_NEG: state_d = S_NEG;
          MODE_MUL: begin
            mx_d = a_q; my_d = b_q; ctx_d = 1'b0;
            state_d = S_MUL;
          end
          MODE_DIV, MODE_INV: begin
            if ((mode_q == MODE_DIV) ? (b_q == '0) : (a_q == '0)) begin
              st_d    = 1'b1;
              state_d = S_DONE;
            end else begin
              r1_d    = (mode_q == MODE_DIV) ? b_q : a_q;
              t0_d    = '0;
              t1_d    = WIDTH'(1);
              dq_d    = p_q;
              ctx_d   = 1'b1;
              state_d = S_EUC_DIV;
            end
          end
          default: state_d = S_DONE;
        endcase
      end
      S_NEG: begin
        ua = {2'b00, p_q};
        ub = ~{2'b00, (mode_q == MODE_NEG) ? a_q : b_q} + (WIDTH+2)'(1);
        if (mode_q == MODE_NEG) begin
          res_d   = uout[WIDTH-1:0];
          state_d = S_DONE;
        end else begin
          b_d     = uout[WIDTH-1:0];
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        ua      = {2'b00, a_q};
        ub      = {2'b00, b_q};
        res_d   = uout[WIDTH-1:0];
        state_d = S_DONE;
      end
      S_MUL: begin
        if (!phase_q) begin
          ua      = {1'b0, acc_q, 1'b0};
          acc_d   = uout[WIDTH-1:0];
          phase_d = 1'b1;
        end else begin
          ua      = {2'b00, acc_q};
          ub      = mx_q[WIDTH-1] ? {2'b00, my_q} : '0;
          acc_d   = uout[WIDTH-1:0];
          mx_d    = {mx_q[WIDTH-2:0], 1'b0};
          phase_d = 1'b0;
          cnt_d   = cnt_q - CntW'(1);
          if (last) begin
            if (ctx_q) state_d = S_EUC_NEG;
            else begin
              res_d   = uout[WIDTH-1:0];
              state_d = S_DONE;
            end
          end
        end
      end
      S_EUC_DIV: begin
        // one restoring division step of r0 / r1, quotient bits MSB first
        ua    = {1'b0, rem_q, dq_q[WIDTH-1]};
        um    = {2'b00, r1_q};
        rem_d = uout[WIDTH-1:0];
        quo_d = {quo_q[WIDTH-2:0], uge};
        dq_d  = {dq_q[WIDTH-2:0], 1'b0};
        cnt_d = cnt_q - CntW'(1);
        if (last) state_d = S_EUC_QRED;
      end
      S_EUC_QRED: begin
        // quotient can equal p on the first pass
        ua      = {2'b00, quo_q};
        mx_d    = uout[WIDTH-1:0];
        my_d    = t1_q;
        acc_d   = '0;
        phase_d = 1'b0;
        cnt_d   = CntW'(WIDTH);
        state_d = S_MUL;
      end
      S_EUC_NEG: begin
        ua      = {2'b00, p_q};
        ub      = ~{2'b00, acc_q} + (WIDTH+2)'(1);
        acc_d   = uout[WIDTH-1:0];
        state_d = S_EUC_ADD;
      end
      S_EUC_ADD: begin
        ua   = {2'b00, t0_q};
        ub   = {2'b00, acc_q};
        r1_d = rem_q;
        t0_d = t1_q;
        t1_d = uout[WIDTH-1:0];
        if (rem_q == '0) begin
          if (mode_q == MODE_INV) begin
            res_d   = t1_q;
            state_d = S_DONE;
          end else begin
            mx_d    = a_q;
            my_d    = t1_q;
            acc_d   = '0;
            phase_d = 1'b0;
            cnt_d   = CntW'(WIDTH);
            ctx_d   = 1'b0;
            state_d = S_MUL;
          end
        end else begin
          dq_d    = r1_q;
          rem_d   = '0;
          quo_d   = '0;
          cnt_d   = CntW'(WIDTH);
          state_d = S_EUC_DIV;
        end
      end
      S_DONE: begin
        if (!ovalid_q || rsp_o.ready) begin
          ovalid_d = 1'b1;
          ores_d   = res_q;
          ost_d    = st_q;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      mod_q    <= WIDTH'(2);
      ovalid_q <= 1'b0;
      cnt_q    <= '0;
      phase_q  <= 1'b0;
      ctx_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      cnt_q    <= cnt_d;
      phase_q  <= phase_d;
      ctx_q    <= ctx_d;
      if (cfg_we_i) mod_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d; mode_q <= mode_d; a_q <= a_d; b_q <= b_d;
    r1_q <= r1_d; t0_q <= t0_d; t1_q <= t1_d;
    rem_q <= rem_d; quo_q <= quo_d; dq_q <= dq_d;
    mx_q <= mx_d; my_q <= my_d; acc_q <= acc_d;
    res_q <= res_d; st_q <= st_d;
    ores_q <= ores_d; ost_q <= ost_d;
  end

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.status |-> rsp_o.result == '0)
    else $error("error response with nonzero result");
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> state_q == S_RED_A)
    else $error("accepted request did not start reduction");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(WIDTH))
    else $error("step counter out of range");
endmodule
